@@ rtl/sefe_pkg.sv @@
// shared types and framing codes for the stx/etx frame encoder
package sefe_pkg;

  localparam logic [7:0]  CODE_DLE   = 8'h10;
  localparam logic [7:0]  CODE_STX   = 8'h02;
  localparam logic [7:0]  CODE_ETX   = 8'h03;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // one classified payload word as handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] crc;
  } sefe_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sefe_qstat_t;

  function automatic logic is_ctrl(input logic [7:0] b);
    is_ctrl = (b == CODE_DLE) || (b == CODE_STX) || (b == CODE_ETX);
  endfunction

endpackage

@@ rtl/sefe_front.sv @@
// front end: accepts payload words, tracks frame state and folds the crc
module sefe_front import sefe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  sefe_qstat_t q_stat,
  output logic        push,
  output sefe_entry_t push_entry
);

  logic [15:0] crc_r, crc_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic [15:0] crc_seed;

  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (a[0]) begin
        a = (a >> 1) ^ CRC_POLY;
      end else begin
        a = a >> 1;
      end
    end
    crc_fold = a;
  endfunction

  always_comb begin
    in_ready             = !q_stat.full;
    push                 = in_valid && in_ready;
    crc_seed             = frame_open_r ? crc_r : CRC_PRESET;
    crc_nxt              = crc_fold(crc_seed, in_data_byte);
    frame_open_nxt       = !in_last_byte;
    push_entry.data      = in_data_byte;
    push_entry.first     = !frame_open_r;
    push_entry.last      = in_last_byte;
    push_entry.crc       = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= CRC_PRESET;
      frame_open_r <= 1'b0;
    end else if (push) begin
      crc_r        <= crc_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

@@ rtl/sefe_queue.sv @@
// short register queue between front and back
module sefe_queue import sefe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sefe_entry_t push_entry,
  input  logic        pop,
  output sefe_entry_t head,
  output sefe_qstat_t q_stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sefe_entry_t   mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  always_comb begin
    q_stat.full  = (count_r == CW'(DEPTH));
    q_stat.empty = (count_r == '0);
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    head         = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/sefe_back.sv @@
// back end: walks each queued entry and emits framed words through an output register
module sefe_back import sefe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sefe_entry_t head,
  input  sefe_qstat_t q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end_of_run,
  output logic        out_frame_end
);

  typedef enum logic [3:0] {
    P_START, P_STX, P_DATA, P_DLE_HI, P_HI, P_DLE_LO, P_LO, P_ETX, P_DONE
  } pos_t;

  pos_t       pos_r, cur_pos, nxt_pos;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_of_run_r, out_frame_end_r;
  logic       load;
  logic [7:0] cur_byte;

  always_comb begin
    cur_pos = (pos_r == P_START) ? (head.first ? P_STX : P_DATA) : pos_r;
    nxt_pos  = P_DONE;
    cur_byte = head.data;
    unique case (cur_pos)
      P_STX: begin
        cur_byte = CODE_STX;
        nxt_pos  = P_DATA;
      end
      P_DATA: begin
        cur_byte = head.data;
        if (head.last) begin
          nxt_pos = is_ctrl(head.crc[15:8]) ? P_DLE_HI : P_HI;
        end else begin
          nxt_pos = P_DONE;
        end
      end
      P_DLE_HI: begin
        cur_byte = CODE_DLE;
        nxt_pos  = P_HI;
      end
      P_HI: begin
        cur_byte = head.crc[15:8];
        nxt_pos  = is_ctrl(head.crc[7:0]) ? P_DLE_LO : P_LO;
      end
      P_DLE_LO: begin
        cur_byte = CODE_DLE;
        nxt_pos  = P_LO;
      end
      P_LO: begin
        cur_byte = head.crc[7:0];
        nxt_pos  = P_ETX;
      end
      P_ETX: begin
        cur_byte = CODE_ETX;
        nxt_pos  = P_DONE;
      end
      default: begin
        cur_byte = head.data;
        nxt_pos  = P_DONE;
      end
    endcase
    load = !out_valid_r || out_ready;
    pop  = load && !q_stat.empty && (nxt_pos == P_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= P_START;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_stat.empty;
      if (!q_stat.empty) begin
        out_byte_r       <= cur_byte;
        out_end_of_run_r <= (nxt_pos == P_DONE);
        out_frame_end_r  <= (cur_pos == P_ETX);
        pos_r            <= (nxt_pos == P_DONE) ? P_START : nxt_pos;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_end_of_run = out_end_of_run_r;
  assign out_frame_end  = out_frame_end_r;

endmodule

@@ rtl/stx_etx_frame_encoder_crc16.sv @@
// stx/etx frame encoder with crc-16 (0xa001, preset 0xffff), top level
// path: each accepted item enters a queue entry, then the back's output register
// throughput: one output word per cycle while out_ready is high and entries wait,
//   from the back sequencer's output register; a mid-message byte gives one word,
//   a first byte two, a last four to six, one more if it also opens the message
// input accepts one word per cycle while the QUEUE_DEPTH-entry queue has room
// reset: synchronous active-low rst_n closes any open frame and empties the queue
module stx_etx_frame_encoder_crc16 import sefe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_run,
  output logic       out_frame_end
);

  sefe_qstat_t q_stat;
  sefe_entry_t push_entry, head;
  logic        push, pop;

  sefe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  sefe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sefe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_frame_end  (out_frame_end)
  );

endmodule

@@ rtl/sefe_checker.sv @@
// port-level checker for the frame encoder and its bind
module sefe_checker import sefe_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_end_of_run,
  input logic       out_frame_end
);

  // closing word is etx and ends its run
  a_etx_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> (out_byte == CODE_ETX) && out_end_of_run)
    else $error("frame end word is not a terminating etx");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_end_of_run) && $stable(out_frame_end))
    else $error("stalled output word changed");

  // no word right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stx_etx_frame_encoder_crc16 sefe_checker u_sefe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_end_of_run (out_end_of_run),
  .out_frame_end  (out_frame_end)
);

@@ tb/sefe_frame_checker.sv @@
// checker for the stx/etx frame encoder: predicts the framed word stream and compares it
`timescale 1ns / 1ps

package sefe_tb_pkg;

  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ sefe_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module sefe_frame_checker import sefe_pkg::*; import sefe_tb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_end_of_run,
  input  logic       out_frame_end,
  output int         pending_words,
  output int         mismatches
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       etx;
  } framed_word_t;

  framed_word_t framed_q[$];
  logic [15:0]  crc_run;
  logic         frame_open;
  int           fail_tally;

  task automatic frame_payload_word(input logic [7:0] d, input logic l);
    logic [7:0] hi;
    logic [7:0] lo;
    if (!frame_open) begin
      framed_q.push_back('{CODE_STX, 1'b0, 1'b0});
      crc_run = CRC_PRESET;
      frame_open = 1'b1;
    end
    framed_q.push_back('{d, !l, 1'b0});
    crc_run = crc16_fold(crc_run, d);
    if (l) begin
      hi = crc_run[15:8];
      lo = crc_run[7:0];
      if (hi inside {CODE_DLE, CODE_STX, CODE_ETX}) framed_q.push_back('{CODE_DLE, 1'b0, 1'b0});
      framed_q.push_back('{hi, 1'b0, 1'b0});
      if (lo inside {CODE_DLE, CODE_STX, CODE_ETX}) framed_q.push_back('{CODE_DLE, 1'b0, 1'b0});
      framed_q.push_back('{lo, 1'b0, 1'b0});
      framed_q.push_back('{CODE_ETX, 1'b1, 1'b1});
      frame_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    framed_word_t want;
    if (!rst_n) begin
      framed_q.delete();
      crc_run = CRC_PRESET;
      frame_open = 1'b0;
      fail_tally = 0;
      pending_words <= 0;
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready) frame_payload_word(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected word: out_byte %02h", out_byte);
          fail_tally++;
        end else begin
          want = framed_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte expected %02h actual %02h", want.data, out_byte);
            fail_tally++;
          end
          if (out_end_of_run !== want.run_end) begin
            $error("out_end_of_run expected %0b actual %0b", want.run_end, out_end_of_run);
            fail_tally++;
          end
          if (out_frame_end !== want.etx) begin
            $error("out_frame_end expected %0b actual %0b", want.etx, out_frame_end);
            fail_tally++;
          end
        end
      end
      pending_words <= framed_q.size();
      mismatches <= fail_tally;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench top for the stx/etx frame encoder: stimulus, idling, timeout and verdict
`timescale 1ns / 1ps

module tb;
  import sefe_pkg::*;
  import sefe_tb_pkg::*;

  localparam int ITEM_TARGET = 395;
  localparam int CALM_AFTER  = 335;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 300000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_end_of_run;
  logic       out_frame_end;

  int pending_words;
  int mismatches;
  int items_sent;
  int cycle_count = 0;
  bit calm;
  bit burst;
  bit hold_long;
  bit long_done;
  bit pause_done;

  stx_etx_frame_encoder_crc16 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_frame_end  (out_frame_end)
  );

  sefe_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_frame_end  (out_frame_end),
    .pending_words  (pending_words),
    .mismatches     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random stalls, plus one long hold on request
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_long = 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer_word(input logic [7:0] d, input logic l);
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic take_break();
    if (!calm && !burst && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials [5];
    specials = '{CODE_DLE, CODE_STX, CODE_ETX, 8'h00, 8'hFF};
    if ($urandom_range(0, 7) == 0) return specials[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // aim: steer the final byte so that a crc byte needs a dle escape
  task automatic send_message(input int len, input bit aim);
    logic [15:0] run_crc;
    logic [15:0] probe;
    logic [7:0]  d;
    logic [7:0]  cand;
    logic [7:0]  start;
    bit          found;
    run_crc = CRC_PRESET;
    for (int i = 0; i < len; i++) begin
      d = pick_byte();
      if (aim && i == len - 1) begin
        start = 8'($urandom_range(0, 255));
        found = 1'b0;
        for (int k = 0; k < 256; k++) begin
          cand = start + 8'(k);
          probe = crc16_fold(run_crc, cand);
          if (!found && (is_ctrl(probe[15:8]) || is_ctrl(probe[7:0]))) begin
            d = cand;
            found = 1'b1;
          end
        end
      end
      offer_word(d, i == len - 1);
      run_crc = crc16_fold(run_crc, d);
      take_break();
    end
  endtask

  initial begin
    int len;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    items_sent = 0;
    calm = 1'b0;
    burst = 1'b0;
    hold_long = 1'b0;
    long_done = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-word messages at the extremes and on the control codes
    offer_word(8'h00, 1'b1);
    offer_word(8'hFF, 1'b1);
    offer_word(CODE_DLE, 1'b1);
    offer_word(CODE_STX, 1'b1);
    offer_word(CODE_ETX, 1'b1);
    // control codes inside a payload go through unescaped
    offer_word(CODE_STX, 1'b0);
    offer_word(CODE_DLE, 1'b0);
    offer_word(CODE_ETX, 1'b0);
    offer_word(8'hFF, 1'b0);
    offer_word(8'h00, 1'b1);
    offer_word(8'hA5, 1'b0);
    offer_word(8'h5A, 1'b1);
    // crc bytes that need escaping
    send_message(1, 1'b1);
    send_message(1, 1'b1);
    send_message(3, 1'b1);
    send_message(2, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_AFTER) calm = 1'b1;
      if (!long_done && items_sent >= 150) begin
        long_done = 1'b1;
        hold_long = 1'b1;
        burst = 1'b1;
        send_message(24, 1'b0);
        burst = 1'b0;
      end else if (!pause_done && items_sent >= 260) begin
        pause_done = 1'b1;
        drain();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        send_message(len, $urandom_range(0, 3) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
